>>> rtl/core/trapezoid_transition_pixel_map_defines.svh
// ----------------------------------------------------------------------------
// Trapezoid transition pixel map assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_TRANSITION_PIXEL_MAP_DEFINES_SVH
`define TRAPEZOID_TRANSITION_PIXEL_MAP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define TTPM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define TTPM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ttpm_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid transition pixel map package
// Register map, reset values, configuration bundle and source codes.
// ----------------------------------------------------------------------------
package ttpm_pkg;

	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ROW_STEP      = 2'd2;
	localparam logic [1:0] REG_WIDTH_STEP    = 2'd3;

	localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd800;
	localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;
	localparam logic [7:0]  RST_ROW_STEP      = 8'd5;
	localparam logic [7:0]  RST_WIDTH_STEP    = 8'd2;

	typedef struct packed {
		logic [11:0] screen_width;
		logic [11:0] screen_height;
		logic [7:0]  row_step;
		logic [7:0]  width_step;
	} cfg_t;

	typedef enum logic [1:0] {
		SEL_HOLD     = 2'd0,
		SEL_OUTGOING = 2'd1,
		SEL_INCOMING = 2'd2
	} sel_t;

endpackage

>>> rtl/core/trapezoid_transition_pixel_map.sv
// Throughput: one pixel per cycle; three restoring dividers, one quotient
// bit per stage, set the depth (19 stages, then 12 stages for two in parallel).
// A stall at the output holds the whole pipeline in place.
// Reset clears all valid bits and loads the registers with their defaults.
// ----------------------------------------------------------------------------
// Trapezoid transition pixel map
// Maps a frame index and screen pixel to a source image and source address.
// ----------------------------------------------------------------------------
`include "trapezoid_transition_pixel_map_defines.svh"

module trapezoid_transition_pixel_map #(
	parameter int COORD_BITS = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ttpm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [10:0]                 frame_index,
	input  logic [10:0]                 pixel_x,
	input  logic [10:0]                 pixel_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  source_select,
	output logic [21:0]                 source_address,
	output logic                        finished
);

	localparam int         CB    = (COORD_BITS < 11) ? COORD_BITS : 11;
	localparam logic [10:0] CMASK = 11'((1 << CB) - 1);

	typedef struct packed {
		logic        fin;
		logic        band;
		logic        insc;
		logic        ge2;
		logic        jnz;
		logic [10:0] x;
		logic [10:0] y;
		logic [18:0] m;
		logic [23:0] jh;
		logic [11:0] nh;
	} d1_side_t;

	typedef struct packed {
		ttpm_pkg::sel_t sel;
		logic           fin;
	} d2_side_t;

	typedef struct packed {
		logic [10:0] x;
		logic [10:0] y;
	} d3_side_t;

	ttpm_pkg::cfg_t cfg;
	logic           en;

	ttpm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Stage 1: masked coordinates and per-frame products.
	logic        v_s1;
	logic [10:0] x_s1, y_s1;
	logic [18:0] rk_s1, m_s1;
	logic [10:0] km;

	assign km = frame_index & CMASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= pixel_x & CMASK;
			y_s1  <= pixel_y & CMASK;
			rk_s1 <= 19'(km) * 19'(cfg.row_step);
			m_s1  <= 19'(km) * 19'(cfg.width_step);
		end
	end

	// Stage 2: frame height, region tests and trapezoid row.
	logic        v_s2, fin_s2, band_s2, insc_s2, ge2_s2;
	logic [11:0] j_s2, nh_s2;
	logic [10:0] x_s2, y_s2;
	logic [18:0] m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s2  <= rk_s1 >= 19'(cfg.screen_height);
			band_s2 <= 19'(y_s1) < rk_s1;
			insc_s2 <= (12'(x_s1) < cfg.screen_width) && (12'(y_s1) < cfg.screen_height);
			ge2_s2  <= rk_s1 >= 19'd2;
			j_s2    <= 12'(19'(y_s1) - rk_s1);
			nh_s2   <= 12'(19'(cfg.screen_height) - rk_s1);
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			m_s2    <= m_s1;
		end
	end

	// Stage 3: numerator products.
	logic        v_s3;
	logic [30:0] mj_s3;
	d1_side_t    d1i_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mj_s3       <= 31'(m_s2) * 31'(j_s2);
			d1i_s3.fin  <= fin_s2;
			d1i_s3.band <= band_s2;
			d1i_s3.insc <= insc_s2;
			d1i_s3.ge2  <= ge2_s2;
			d1i_s3.jnz  <= j_s2 != 12'd0;
			d1i_s3.x    <= x_s2;
			d1i_s3.y    <= y_s2;
			d1i_s3.m    <= m_s2;
			d1i_s3.jh   <= 24'(j_s2) * 24'(cfg.screen_height);
			d1i_s3.nh   <= nh_s2;
		end
	end

	logic        d1_vld;
	logic [18:0] q1;
	d1_side_t    d1o;

	ttpm_div #(.DW(12), .QW(19), .SW($bits(d1_side_t))) u_div_width (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s3),
		.in_rem   (mj_s3[30:19]),
		.in_num   (mj_s3[18:0]),
		.in_den   (d1i_s3.nh),
		.in_side  (d1i_s3),
		.out_vld  (d1_vld),
		.out_quot (q1),
		.out_side (d1o)
	);

	// Stage 4: row width, centering offset and source choice.
	logic signed [20:0] nw_c;
	logic signed [21:0] nwo_c;
	logic [18:0]        off_c;
	logic [11:0]        i_c;
	logic               xlt_c, xgt_c, side_c, outg_c;
	ttpm_pkg::sel_t     sel_c;

	always_comb begin
		nw_c   = $signed({9'd0, cfg.screen_width}) - $signed({2'd0, d1o.m})
		       + $signed({2'd0, q1});
		off_c  = (d1o.m - q1) >> 1;
		nwo_c  = $signed({nw_c[20], nw_c}) + $signed({3'd0, off_c});
		xlt_c  = 19'(d1o.x) < off_c;
		xgt_c  = $signed({11'd0, d1o.x}) > nwo_c;
		i_c    = 12'(19'(d1o.x) - off_c);
		side_c = (xlt_c || xgt_c) && (d1o.x != 11'd0) && (d1o.jnz || d1o.ge2);
		outg_c = (nw_c > 21'sd0) && !xlt_c && ($signed({9'd0, i_c}) < nw_c)
		       && (d1o.x != 11'd0) && (d1o.y != 11'd0);
		if (d1o.fin || !d1o.insc) begin
			sel_c = ttpm_pkg::SEL_HOLD;
		end else if (d1o.band || side_c) begin
			sel_c = ttpm_pkg::SEL_INCOMING;
		end else if (outg_c) begin
			sel_c = ttpm_pkg::SEL_OUTGOING;
		end else begin
			sel_c = ttpm_pkg::SEL_HOLD;
		end
	end

	logic           v_s4, fin_s4;
	ttpm_pkg::sel_t sel_s4;
	logic [10:0]    x_s4, y_s4;
	logic [11:0]    i_s4, nw_s4, nh_s4;
	logic [23:0]    jh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s4 <= d1o.fin;
			sel_s4 <= sel_c;
			x_s4   <= d1o.x;
			y_s4   <= d1o.y;
			i_s4   <= i_c;
			nw_s4  <= nw_c[11:0];
			nh_s4  <= d1o.nh;
			jh_s4  <= d1o.jh;
		end
	end

	// Stage 5: column numerator.
	logic        v_s5;
	logic [23:0] iw_s5, jh_s5;
	logic [11:0] nw_s5, nh_s5;
	d2_side_t    d2i_s5;
	d3_side_t    d3i_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iw_s5      <= 24'(i_s4) * 24'(cfg.screen_width);
			jh_s5      <= jh_s4;
			nw_s5      <= nw_s4;
			nh_s5      <= nh_s4;
			d2i_s5.sel <= sel_s4;
			d2i_s5.fin <= fin_s4;
			d3i_s5.x   <= x_s4;
			d3i_s5.y   <= y_s4;
		end
	end

	logic        d2_vld, d3_vld;
	logic [11:0] sr, sc;
	d2_side_t    d2o;
	d3_side_t    d3o;

	ttpm_div #(.DW(12), .QW(12), .SW($bits(d2_side_t))) u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s5),
		.in_rem   (jh_s5[23:12]),
		.in_num   (jh_s5[11:0]),
		.in_den   (nh_s5),
		.in_side  (d2i_s5),
		.out_vld  (d2_vld),
		.out_quot (sr),
		.out_side (d2o)
	);

	ttpm_div #(.DW(12), .QW(12), .SW($bits(d3_side_t))) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s5),
		.in_rem   (iw_s5[23:12]),
		.in_num   (iw_s5[11:0]),
		.in_den   (nw_s5),
		.in_side  (d3i_s5),
		.out_vld  (d3_vld),
		.out_quot (sc),
		.out_side (d3o)
	);

	// Output stage: address composition.
	logic [11:0]    row_c, col_c;
	logic [24:0]    addr_c;
	ttpm_pkg::sel_t sel_q;
	logic [21:0]    addr_q;
	logic           fin_q;

	always_comb begin
		if (d2o.sel == ttpm_pkg::SEL_INCOMING) begin
			row_c = 12'(d3o.y);
			col_c = 12'(d3o.x);
		end else begin
			row_c = sr;
			col_c = sc;
		end
		addr_c = 25'(row_c) * 25'(cfg.screen_width) + 25'(col_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_q  <= d2o.sel;
			fin_q  <= d2o.fin;
			addr_q <= (d2o.sel == ttpm_pkg::SEL_HOLD) ? 22'd0 : addr_c[21:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign source_select  = sel_q;
	assign source_address = addr_q;
	assign finished       = fin_q;

	`TTPM_ASSERT_ALWAYS(a_div_lanes_aligned, d2_vld == d3_vld, "divider lanes out of step")
	`TTPM_ASSERT_IMPLY(a_finished_holds, out_valid_q && fin_q,
		sel_q == ttpm_pkg::SEL_HOLD, "finished transfer does not hold")
	`TTPM_ASSERT_IMPLY(a_hold_zero_addr, out_valid_q && sel_q == ttpm_pkg::SEL_HOLD,
		addr_q == 22'd0, "hold transfer carries a nonzero address")

endmodule

>>> rtl/core/ttpm_cfg.sv
// ----------------------------------------------------------------------------
// Trapezoid transition pixel map configuration registers
// APB-style register file holding screen size and per-frame steps.
// ----------------------------------------------------------------------------
module ttpm_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ttpm_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output ttpm_pkg::cfg_t               cfg
);

	ttpm_pkg::cfg_t cfg_q;
	logic           wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= ttpm_pkg::RST_SCREEN_WIDTH;
			cfg_q.screen_height <= ttpm_pkg::RST_SCREEN_HEIGHT;
			cfg_q.row_step      <= ttpm_pkg::RST_ROW_STEP;
			cfg_q.width_step    <= ttpm_pkg::RST_WIDTH_STEP;
		end else if (wr) begin
			case (paddr[3:2])
				ttpm_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[11:0];
				ttpm_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[11:0];
				ttpm_pkg::REG_ROW_STEP:      cfg_q.row_step      <= pwdata[7:0];
				ttpm_pkg::REG_WIDTH_STEP:    cfg_q.width_step    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ttpm_pkg::REG_SCREEN_WIDTH:  prdata = 32'(cfg_q.screen_width);
			ttpm_pkg::REG_SCREEN_HEIGHT: prdata = 32'(cfg_q.screen_height);
			ttpm_pkg::REG_ROW_STEP:      prdata = 32'(cfg_q.row_step);
			ttpm_pkg::REG_WIDTH_STEP:    prdata = 32'(cfg_q.width_step);
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

>>> rtl/core/ttpm_div.sv
// ----------------------------------------------------------------------------
// Trapezoid transition pixel map pipelined divider
// Restoring division, one quotient bit per register stage, with sideband.
// The starting partial remainder must be below the divisor.
// ----------------------------------------------------------------------------
module ttpm_div #(
	parameter int DW = 12,
	parameter int QW = 12,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [QW-1:0] out_quot,
	output logic [SW-1:0] out_side
);

	logic          vld_s  [QW+1];
	logic [DW-1:0] rem_s  [QW+1];
	logic [QW-1:0] num_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_rem;
	assign num_s[0]  = in_num;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem_s[g], num_s[g][QW-1]};
			diff  = trial - {1'b0, den_s[g]};
			ge    = trial >= {1'b0, den_s[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				num_s[g+1]  <= (num_s[g] << 1) | QW'(ge);
				den_s[g+1]  <= den_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign out_quot = num_s[QW];
	assign out_side = side_s[QW];

endmodule
